@@ rtl/ffa_pkg.sv @@
`timescale 1ns / 1ps
package ffa_pkg;

    localparam int DATA_W = 48;
    localparam int ALU_W  = 50;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_REL   = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam int DEF_MAX_EXTENTS  = 64;
    localparam int DEF_MAX_ALLOCS   = 64;
    localparam int DEF_HEADER_BYTES = 16;
    localparam int DEF_WORD_BYTES   = 8;

    localparam logic [DATA_W-1:0] DEF_MIN_REGION = 48'd65536;

endpackage

@@ rtl/ffa_alu.sv @@
`timescale 1ns / 1ps
module ffa_alu
(
    input  logic [ffa_pkg::ALU_W-1:0] a,
    input  logic [ffa_pkg::ALU_W-1:0] b,
    input  logic [ffa_pkg::ALU_W-1:0] c,
    output logic [ffa_pkg::ALU_W-1:0] sum,
    output logic                      ge
);
    import ffa_pkg::*;

    assign sum = a + b + c;
    assign ge  = (a >= b);

endmodule

@@ rtl/first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
// Work per item: the extent table is scanned and shifted one extent at a time, and allocation
// slots are searched one at a time, on release and on allocate.
// Throughput: one item at a time; busy stays high until the result strobe, set by the
// extent table's single read port and the shared adder/comparator.
// Reset: asynchronous, clears the extent count and allocation valid bits and restores
// min_region_size to its default; configuration beats are taken only while idle.
// The result is shown for one cycle on done; the receiver cannot stall.
module first_fit_heap_allocator
#(
    parameter int MAX_EXTENTS  = ffa_pkg::DEF_MAX_EXTENTS,
    parameter int MAX_ALLOCS   = ffa_pkg::DEF_MAX_ALLOCS,
    parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
    parameter int WORD_BYTES   = ffa_pkg::DEF_WORD_BYTES
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 opcode,
    input  logic [ffa_pkg::DATA_W-1:0] address,
    input  logic [ffa_pkg::DATA_W-1:0] length,
    input  logic                       usable,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ffa_pkg::DATA_W-1:0] cfg_data,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [ffa_pkg::DATA_W-1:0] result_address,
    output logic [ffa_pkg::DATA_W-1:0] free_total
);
    import ffa_pkg::*;

    localparam int EXT_AW = $clog2(MAX_EXTENTS);
    localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
    localparam int AL_AW  = $clog2(MAX_ALLOCS);
    localparam logic [ALU_W-1:0] HDR   = ALU_W'(HEADER_BYTES);
    localparam logic [ALU_W-1:0] HDR2  = ALU_W'(2 * HEADER_BYTES);
    localparam logic [ALU_W-1:0] WRDM1 = ALU_W'(WORD_BYTES - 1);
    localparam logic [DATA_W-1:0] HDR_D = DATA_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EXTENTS);
    localparam logic [AL_AW-1:0] SLOT_LAST = AL_AW'(MAX_ALLOCS - 1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ADD_CHK  = 5'd1;
    localparam logic [4:0] S_ADD_SUB  = 5'd2;
    localparam logic [4:0] S_FP_RD    = 5'd3;
    localparam logic [4:0] S_FP_EV    = 5'd4;
    localparam logic [4:0] S_INS_RD   = 5'd5;
    localparam logic [4:0] S_INS_WR   = 5'd6;
    localparam logic [4:0] S_REM_RD   = 5'd7;
    localparam logic [4:0] S_REM_WR   = 5'd8;
    localparam logic [4:0] S_AL_RND   = 5'd9;
    localparam logic [4:0] S_AF_RD    = 5'd10;
    localparam logic [4:0] S_AF_EV    = 5'd11;
    localparam logic [4:0] S_AS       = 5'd12;
    localparam logic [4:0] S_AL_T     = 5'd13;
    localparam logic [4:0] S_AL_CMP   = 5'd14;
    localparam logic [4:0] S_SPL1     = 5'd15;
    localparam logic [4:0] S_SPL2     = 5'd16;
    localparam logic [4:0] S_AL_REC   = 5'd17;
    localparam logic [4:0] S_RS_RD    = 5'd18;
    localparam logic [4:0] S_RS_EV    = 5'd19;
    localparam logic [4:0] S_RL_PRV   = 5'd20;
    localparam logic [4:0] S_RL_PRVEV = 5'd21;
    localparam logic [4:0] S_RL_NXT   = 5'd22;
    localparam logic [4:0] S_RL_NXTEV = 5'd23;
    localparam logic [4:0] S_RL_ACT   = 5'd24;
    localparam logic [4:0] S_RL_BOTH2 = 5'd25;
    localparam logic [4:0] S_RL_FREE  = 5'd26;
    localparam logic [4:0] S_Q_RD     = 5'd27;
    localparam logic [4:0] S_Q_EV     = 5'd28;

    logic [2*DATA_W-1:0] ext_mem [MAX_EXTENTS];
    logic [2*DATA_W-1:0] alc_mem [MAX_ALLOCS];

    logic [4:0]          state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [DATA_W-1:0]   addr_reg, addr_next;
    logic [DATA_W-1:0]   len_reg, len_next;
    logic                usable_reg, usable_next;
    logic [DATA_W-1:0]   min_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [AL_AW-1:0]    slot_reg, slot_next;
    logic [ALU_W-1:0]    size_reg, size_next;
    logic [ALU_W-1:0]    acc_reg, acc_next;
    logic [DATA_W-1:0]   blk_base_reg, blk_base_next;
    logic [DATA_W-1:0]   blk_size_reg, blk_size_next;
    logic [DATA_W-1:0]   ext_base_reg, ext_base_next;
    logic [DATA_W-1:0]   ext_size_reg, ext_size_next;
    logic [DATA_W-1:0]   nxt_size_reg, nxt_size_next;
    logic                mprev_reg, mprev_next;
    logic                mnext_reg, mnext_next;
    logic [MAX_ALLOCS-1:0] valid_reg, valid_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [DATA_W-1:0]   res_reg, res_next;
    logic [DATA_W-1:0]   total_reg, total_next;

    logic [2*DATA_W-1:0] ext_rd_reg;
    logic [2*DATA_W-1:0] alc_rd_reg;
    logic                ext_we;
    logic [EXT_AW-1:0]   ext_wa;
    logic [EXT_AW-1:0]   ext_ra;
    logic [2*DATA_W-1:0] ext_wd;
    logic                alc_we;
    logic [2*DATA_W-1:0] alc_wd;

    logic [CNT_W-1:0]    idx_m1;
    logic [CNT_W-1:0]    idx_p1;
    logic [CNT_W-1:0]    pos_m1;
    logic [DATA_W-1:0]   rd_base;
    logic [DATA_W-1:0]   rd_size;
    logic [DATA_W-1:0]   al_base;
    logic [DATA_W-1:0]   al_size;

    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic [ALU_W-1:0]    alu_c;
    logic [ALU_W-1:0]    alu_sum;
    logic                alu_ge;

    ffa_alu u_alu
    (
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .sum (alu_sum),
        .ge  (alu_ge)
    );

    assign idx_m1  = idx_reg - CNT_W'(1);
    assign idx_p1  = idx_reg + CNT_W'(1);
    assign pos_m1  = pos_reg - CNT_W'(1);
    assign rd_base = ext_rd_reg[2*DATA_W-1:DATA_W];
    assign rd_size = ext_rd_reg[DATA_W-1:0];
    assign al_base = alc_rd_reg[2*DATA_W-1:DATA_W];
    assign al_size = alc_rd_reg[DATA_W-1:0];

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = (state_reg == S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign result_address = res_reg;
    assign free_total     = total_reg;

    always_ff @(posedge clk)
    begin
        ext_rd_reg <= ext_mem[ext_ra];
        if (ext_we)
        begin
            ext_mem[ext_wa] <= ext_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        alc_rd_reg <= alc_mem[slot_reg];
        if (alc_we)
        begin
            alc_mem[slot_reg] <= alc_wd;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        usable_next   = usable_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        slot_next     = slot_reg;
        size_next     = size_reg;
        acc_next      = acc_reg;
        blk_base_next = blk_base_reg;
        blk_size_next = blk_size_reg;
        ext_base_next = ext_base_reg;
        ext_size_next = ext_size_reg;
        nxt_size_next = nxt_size_reg;
        mprev_next    = mprev_reg;
        mnext_next    = mnext_reg;
        valid_next    = valid_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        res_next      = res_reg;
        total_next    = total_reg;
        ext_we        = 1'b0;
        ext_wa        = idx_reg[EXT_AW-1:0];
        ext_ra        = idx_reg[EXT_AW-1:0];
        ext_wd        = ext_rd_reg;
        alc_we        = 1'b0;
        alc_wd        = {blk_base_reg, blk_size_reg};
        alu_a         = '0;
        alu_b         = '0;
        alu_c         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = opcode;
                    addr_next   = address;
                    len_next    = length;
                    usable_next = usable;
                    idx_next    = '0;
                    slot_next   = '0;
                    acc_next    = '0;
                    case (opcode)
                        OP_ADD:   state_next = S_ADD_CHK;
                        OP_ALLOC: state_next = S_AL_RND;
                        OP_REL:   state_next = S_RS_RD;
                        default:  state_next = S_Q_RD;
                    endcase
                end
            end

            S_ADD_CHK:
            begin
                alu_a = ALU_W'(len_reg);
                alu_b = ALU_W'(min_reg);
                if (!usable_reg || !alu_ge || (len_reg < HDR_D))
                begin
                    done_next   = 1'b1;
                    status_next = ST_UNKNOWN;
                    res_next    = '0;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
                else if (cnt_reg == CNT_MAX)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    res_next    = '0;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_ADD_SUB;
                end
            end

            S_ADD_SUB:
            begin
                alu_a         = ALU_W'(len_reg);
                alu_b         = ~HDR;
                alu_c         = ALU_W'(1);
                blk_size_next = alu_sum[DATA_W-1:0];
                blk_base_next = addr_reg;
                idx_next      = '0;
                state_next    = S_FP_RD;
            end

            S_FP_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    pos_next   = idx_reg;
                    idx_next   = cnt_reg;
                    state_next = (op_reg == OP_ADD) ? S_INS_RD : S_RL_PRV;
                end
                else
                begin
                    state_next = S_FP_EV;
                end
            end

            S_FP_EV:
            begin
                alu_a = ALU_W'(rd_base);
                alu_b = ALU_W'(blk_base_reg);
                if (alu_ge)
                begin
                    pos_next   = idx_reg;
                    idx_next   = cnt_reg;
                    state_next = (op_reg == OP_ADD) ? S_INS_RD : S_RL_PRV;
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = S_FP_RD;
                end
            end

            S_INS_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    ext_we   = 1'b1;
                    ext_wa   = pos_reg[EXT_AW-1:0];
                    ext_wd   = {blk_base_reg, blk_size_reg};
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (op_reg == OP_ADD)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        res_next    = '0;
                        total_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RL_FREE;
                    end
                end
                else
                begin
                    ext_ra     = idx_m1[EXT_AW-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                ext_we     = 1'b1;
                idx_next   = idx_m1;
                state_next = S_INS_RD;
            end

            S_REM_RD:
            begin
                if (idx_p1 >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = (op_reg == OP_ALLOC) ? S_AL_REC : S_RL_FREE;
                end
                else
                begin
                    ext_ra     = idx_p1[EXT_AW-1:0];
                    state_next = S_REM_WR;
                end
            end

            S_REM_WR:
            begin
                ext_we     = 1'b1;
                idx_next   = idx_p1;
                state_next = S_REM_RD;
            end

            S_AL_RND:
            begin
                alu_a = ALU_W'(len_reg);
                alu_b = WRDM1;
                if (len_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOFIT;
                    res_next    = '0;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    size_next  = alu_sum & ~WRDM1;
                    idx_next   = '0;
                    state_next = S_AF_RD;
                end
            end

            S_AF_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOFIT;
                    res_next    = '0;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_AF_EV;
                end
            end

            S_AF_EV:
            begin
                alu_a = ALU_W'(rd_size);
                alu_b = size_reg;
                if (alu_ge)
                begin
                    pos_next      = idx_reg;
                    ext_base_next = rd_base;
                    ext_size_next = rd_size;
                    slot_next     = '0;
                    state_next    = S_AS;
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = S_AF_RD;
                end
            end

            S_AS:
            begin
                if (!valid_reg[slot_reg])
                begin
                    state_next = S_AL_T;
                end
                else if (slot_reg == SLOT_LAST)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    res_next    = '0;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + AL_AW'(1);
                end
            end

            S_AL_T:
            begin
                alu_a      = size_reg;
                alu_b      = HDR;
                acc_next   = alu_sum;
                state_next = S_AL_CMP;
            end

            S_AL_CMP:
            begin
                alu_a         = acc_reg;
                alu_b         = ALU_W'(ext_size_reg);
                blk_base_next = ext_base_reg;
                if (alu_ge)
                begin
                    blk_size_next = ext_size_reg;
                    idx_next      = pos_reg;
                    state_next    = S_REM_RD;
                end
                else
                begin
                    state_next = S_SPL1;
                end
            end

            S_SPL1:
            begin
                alu_a         = ALU_W'(ext_base_reg);
                alu_b         = acc_reg;
                ext_base_next = alu_sum[DATA_W-1:0];
                state_next    = S_SPL2;
            end

            S_SPL2:
            begin
                alu_a         = ALU_W'(ext_size_reg);
                alu_b         = ~acc_reg;
                alu_c         = ALU_W'(1);
                ext_we        = 1'b1;
                ext_wa        = pos_reg[EXT_AW-1:0];
                ext_wd        = {ext_base_reg, alu_sum[DATA_W-1:0]};
                blk_size_next = size_reg[DATA_W-1:0];
                state_next    = S_AL_REC;
            end

            S_AL_REC:
            begin
                alc_we               = 1'b1;
                valid_next[slot_reg] = 1'b1;
                alu_a                = ALU_W'(blk_base_reg);
                alu_b                = HDR;
                done_next            = 1'b1;
                status_next          = ST_OK;
                res_next             = alu_sum[DATA_W-1:0];
                total_next           = '0;
                state_next           = S_IDLE;
            end

            S_RS_RD:
            begin
                state_next = S_RS_EV;
            end

            S_RS_EV:
            begin
                alu_a = ALU_W'(al_base);
                alu_b = HDR;
                if (valid_reg[slot_reg] && (alu_sum[DATA_W-1:0] == addr_reg))
                begin
                    blk_base_next = al_base;
                    blk_size_next = al_size;
                    idx_next      = '0;
                    state_next    = S_FP_RD;
                end
                else if (slot_reg == SLOT_LAST)
                begin
                    done_next   = 1'b1;
                    status_next = ST_UNKNOWN;
                    res_next    = '0;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg + AL_AW'(1);
                    state_next = S_RS_RD;
                end
            end

            S_RL_PRV:
            begin
                mprev_next = 1'b0;
                if (pos_reg != '0)
                begin
                    ext_ra     = pos_m1[EXT_AW-1:0];
                    state_next = S_RL_PRVEV;
                end
                else
                begin
                    state_next = S_RL_NXT;
                end
            end

            S_RL_PRVEV:
            begin
                alu_a         = ALU_W'(rd_base);
                alu_b         = HDR;
                alu_c         = ALU_W'(rd_size);
                mprev_next    = (alu_sum[DATA_W-1:0] == blk_base_reg);
                ext_base_next = rd_base;
                ext_size_next = rd_size;
                state_next    = S_RL_NXT;
            end

            S_RL_NXT:
            begin
                mnext_next = 1'b0;
                if (pos_reg < cnt_reg)
                begin
                    ext_ra     = pos_reg[EXT_AW-1:0];
                    state_next = S_RL_NXTEV;
                end
                else
                begin
                    state_next = S_RL_ACT;
                end
            end

            S_RL_NXTEV:
            begin
                alu_a         = ALU_W'(blk_base_reg);
                alu_b         = HDR;
                alu_c         = ALU_W'(blk_size_reg);
                mnext_next    = (alu_sum[DATA_W-1:0] == rd_base);
                nxt_size_next = rd_size;
                state_next    = S_RL_ACT;
            end

            S_RL_ACT:
            begin
                if (mprev_reg && mnext_reg)
                begin
                    alu_a      = ALU_W'(ext_size_reg);
                    alu_b      = ALU_W'(blk_size_reg);
                    alu_c      = ALU_W'(nxt_size_reg);
                    acc_next   = alu_sum;
                    state_next = S_RL_BOTH2;
                end
                else if (mprev_reg)
                begin
                    alu_a      = ALU_W'(ext_size_reg);
                    alu_b      = HDR;
                    alu_c      = ALU_W'(blk_size_reg);
                    ext_we     = 1'b1;
                    ext_wa     = pos_m1[EXT_AW-1:0];
                    ext_wd     = {ext_base_reg, alu_sum[DATA_W-1:0]};
                    state_next = S_RL_FREE;
                end
                else if (mnext_reg)
                begin
                    alu_a      = ALU_W'(blk_size_reg);
                    alu_b      = HDR;
                    alu_c      = ALU_W'(nxt_size_reg);
                    ext_we     = 1'b1;
                    ext_wa     = pos_reg[EXT_AW-1:0];
                    ext_wd     = {blk_base_reg, alu_sum[DATA_W-1:0]};
                    state_next = S_RL_FREE;
                end
                else if (cnt_reg == CNT_MAX)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    res_next    = '0;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next   = cnt_reg;
                    state_next = S_INS_RD;
                end
            end

            S_RL_BOTH2:
            begin
                alu_a      = acc_reg;
                alu_b      = HDR2;
                ext_we     = 1'b1;
                ext_wa     = pos_m1[EXT_AW-1:0];
                ext_wd     = {ext_base_reg, alu_sum[DATA_W-1:0]};
                idx_next   = pos_reg;
                state_next = S_REM_RD;
            end

            S_RL_FREE:
            begin
                valid_next[slot_reg] = 1'b0;
                done_next            = 1'b1;
                status_next          = ST_OK;
                res_next             = '0;
                total_next           = '0;
                state_next           = S_IDLE;
            end

            S_Q_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    res_next    = '0;
                    total_next  = acc_reg[DATA_W-1:0];
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_Q_EV;
                end
            end

            S_Q_EV:
            begin
                alu_a      = acc_reg;
                alu_b      = ALU_W'(rd_size);
                acc_next   = ALU_W'(alu_sum[DATA_W-1:0]);
                idx_next   = idx_p1;
                state_next = S_Q_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_ADD;
            addr_reg     <= '0;
            len_reg      <= '0;
            usable_reg   <= 1'b0;
            min_reg      <= DEF_MIN_REGION;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            pos_reg      <= '0;
            slot_reg     <= '0;
            size_reg     <= '0;
            acc_reg      <= '0;
            blk_base_reg <= '0;
            blk_size_reg <= '0;
            ext_base_reg <= '0;
            ext_size_reg <= '0;
            nxt_size_reg <= '0;
            mprev_reg    <= 1'b0;
            mnext_reg    <= 1'b0;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            res_reg      <= '0;
            total_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            addr_reg     <= addr_next;
            len_reg      <= len_next;
            usable_reg   <= usable_next;
            if (cfg_valid && cfg_ready)
            begin
                min_reg <= cfg_data;
            end
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            pos_reg      <= pos_next;
            slot_reg     <= slot_next;
            size_reg     <= size_next;
            acc_reg      <= acc_next;
            blk_base_reg <= blk_base_next;
            blk_size_reg <= blk_size_next;
            ext_base_reg <= ext_base_next;
            ext_size_reg <= ext_size_next;
            nxt_size_reg <= nxt_size_next;
            mprev_reg    <= mprev_next;
            mnext_reg    <= mnext_next;
            valid_reg    <= valid_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            res_reg      <= res_next;
            total_reg    <= total_next;
        end
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still working");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("extent count beyond table depth");

    a_valid_chg: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg != $past(valid_reg)) |->
            ($past(state_reg) == S_AL_REC || $past(state_reg) == S_RL_FREE))
        else $error("allocation valid bits changed outside record or free");

endmodule

@@ dv/heap_checker.sv @@
`timescale 1ns / 1ps
module heap_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [1:0]                 opcode,
    input  logic [ffa_pkg::DATA_W-1:0] address,
    input  logic [ffa_pkg::DATA_W-1:0] length,
    input  logic                       usable,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [ffa_pkg::DATA_W-1:0] cfg_data,
    input  logic                       done,
    input  logic [1:0]                 status,
    input  logic [ffa_pkg::DATA_W-1:0] result_address,
    input  logic [ffa_pkg::DATA_W-1:0] free_total,
    output int                         mismatches,
    output int                         waiting
);
    import ffa_pkg::*;

    localparam int        EXTENTS = DEF_MAX_EXTENTS;
    localparam int        SLOTS   = DEF_MAX_ALLOCS;
    localparam bit [63:0] HDR     = 64'(DEF_HEADER_BYTES);
    localparam bit [63:0] WORD    = 64'(DEF_WORD_BYTES);
    localparam bit [63:0] M48     = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed
    {
        logic [1:0]        st;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] total;
    } outcome_t;

    outcome_t  outcome_q[$];
    bit [63:0] ext_base [EXTENTS];
    bit [63:0] ext_size [EXTENTS];
    int        ext_count;
    bit [63:0] blk_base [SLOTS];
    bit [63:0] blk_size [SLOTS];
    bit        blk_live [SLOTS];
    bit [63:0] min_len;

    function automatic void drop_extent(int pos);
        for (int i = pos; i + 1 < ext_count; i++)
        begin
            ext_base[i] = ext_base[i+1];
            ext_size[i] = ext_size[i+1];
        end
        ext_count--;
    endfunction

    function automatic void put_extent(int pos, bit [63:0] b, bit [63:0] s);
        for (int i = ext_count; i > pos; i--)
        begin
            ext_base[i] = ext_base[i-1];
            ext_size[i] = ext_size[i-1];
        end
        ext_base[pos] = b;
        ext_size[pos] = s;
        ext_count++;
    endfunction

    function automatic int first_above(bit [63:0] b);
        int p;
        p = 0;
        while (p < ext_count && ext_base[p] < b)
            p++;
        return p;
    endfunction

    function automatic bit [63:0] end_addr(bit [63:0] b, bit [63:0] s);
        return (b + HDR + s) & M48;
    endfunction

    function automatic outcome_t predict_heap(logic [1:0] op, bit [63:0] a, bit [63:0] l, bit u);
        outcome_t  o;
        bit [63:0] need;
        bit [63:0] b;
        bit [63:0] s;
        int        i;
        int        slot;
        int        p;
        bit        mprev;
        bit        mnext;
        o = '0;
        case (op)
            OP_ADD:
            begin
                if (!u || l < min_len || l < HDR)
                    o.st = ST_UNKNOWN;
                else if (ext_count >= EXTENTS)
                    o.st = ST_FULL;
                else
                begin
                    put_extent(first_above(a), a, l - HDR);
                    o.st = ST_OK;
                end
            end
            OP_ALLOC:
            begin
                need = (l + WORD - 1) & ~(WORD - 1);
                for (i = 0; i < ext_count; i++)
                    if (ext_size[i] >= need)
                        break;
                for (slot = 0; slot < SLOTS; slot++)
                    if (!blk_live[slot])
                        break;
                if (l == 0 || i >= ext_count)
                    o.st = ST_NOFIT;
                else if (slot >= SLOTS)
                    o.st = ST_FULL;
                else
                begin
                    b = ext_base[i];
                    if (ext_size[i] > need + HDR)
                    begin
                        ext_base[i] = end_addr(b, need);
                        ext_size[i] = ext_size[i] - need - HDR;
                        s = need;
                    end
                    else
                    begin
                        s = ext_size[i];
                        drop_extent(i);
                    end
                    blk_base[slot] = b;
                    blk_size[slot] = s;
                    blk_live[slot] = 1'b1;
                    o.addr = DATA_W'((b + HDR) & M48);
                    o.st = ST_OK;
                end
            end
            OP_REL:
            begin
                for (slot = 0; slot < SLOTS; slot++)
                    if (blk_live[slot] && ((blk_base[slot] + HDR) & M48) == a)
                        break;
                if (slot >= SLOTS)
                    o.st = ST_UNKNOWN;
                else
                begin
                    b = blk_base[slot];
                    s = blk_size[slot];
                    p = first_above(b);
                    mprev = p > 0 && end_addr(ext_base[p-1], ext_size[p-1]) == b;
                    mnext = p < ext_count && end_addr(b, s) == ext_base[p];
                    o.st = ST_OK;
                    if (mprev && mnext)
                    begin
                        ext_size[p-1] = (ext_size[p-1] + 2 * HDR + s + ext_size[p]) & M48;
                        drop_extent(p);
                    end
                    else if (mprev)
                        ext_size[p-1] = (ext_size[p-1] + HDR + s) & M48;
                    else if (mnext)
                    begin
                        ext_base[p] = b;
                        ext_size[p] = (s + HDR + ext_size[p]) & M48;
                    end
                    else if (ext_count >= EXTENTS)
                        o.st = ST_FULL;
                    else
                        put_extent(p, b, s);
                    if (o.st == ST_OK)
                        blk_live[slot] = 1'b0;
                end
            end
            default:
            begin
                s = 0;
                for (i = 0; i < ext_count; i++)
                    s = (s + ext_size[i]) & M48;
                o.total = DATA_W'(s);
                o.st = ST_OK;
            end
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            outcome_q.delete();
            ext_count = 0;
            for (int i = 0; i < SLOTS; i++)
                blk_live[i] = 1'b0;
            min_len = 64'(DEF_MIN_REGION);
            mismatches = 0;
            waiting = 0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: st=%0d addr=%h total=%h",
                                 $realtime, status, result_address, free_total);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (status !== want.st || result_address !== want.addr
                        || free_total !== want.total)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp st=%0d addr=%h total=%h, got st=%0d addr=%h total=%h",
                                     $realtime, want.st, want.addr, want.total,
                                     status, result_address, free_total);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                min_len = 64'(cfg_data);
            if (start && !busy)
                outcome_q.push_back(predict_heap(opcode, 64'(address), 64'(length), usable));
            waiting = outcome_q.size();
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import ffa_pkg::*;

    localparam int LIMIT = 2000000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        opcode;
    logic [DATA_W-1:0] address;
    logic [DATA_W-1:0] length;
    logic              usable;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [DATA_W-1:0] cfg_data;
    logic              done;
    logic [1:0]        status;
    logic [DATA_W-1:0] result_address;
    logic [DATA_W-1:0] free_total;
    int                mismatches;
    int                waiting;

    int                issued;
    int                returned;
    int                cycles;
    int                per_op [4];
    logic [1:0]        op_q [$];
    logic [DATA_W-1:0] live_q [$];

    first_fit_heap_allocator dut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .address(address), .length(length), .usable(usable), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done), .status(status),
        .result_address(result_address), .free_total(free_total)
    );

    heap_checker u_heap_checker
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .address(address), .length(length), .usable(usable), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done), .status(status),
        .result_address(result_address), .free_total(free_total),
        .mismatches(mismatches), .waiting(waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        logic [1:0] op;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n && done)
        begin
            returned++;
            if (op_q.size() > 0)
            begin
                op = op_q.pop_front();
                if (op == OP_ALLOC && status == ST_OK)
                    live_q.push_back(result_address);
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand48();
        bit [63:0] r;
        r = {$urandom, $urandom};
        return r[DATA_W-1:0];
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) < pct)
            return $urandom_range(1, 8);
        return 0;
    endfunction

    task automatic send_item(logic [1:0] op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] l,
                             logic u, int gap);
        opcode  <= op;
        address <= a;
        length  <= l;
        usable  <= u;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        issued++;
        per_op[op]++;
        op_q.push_back(op);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (returned != issued)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_min(logic [DATA_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item(int pct);
        int                k;
        int                j;
        int                idx;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] l;
        k = $urandom_range(99);
        j = $urandom_range(9);
        if (k < 15)
        begin
            a = ($urandom_range(9) == 0) ? rand48() : DATA_W'($urandom_range(0, 4095)) << 16;
            if (j < 5)
                l = DATA_W'($urandom_range(0, 32'h30000));
            else if (j < 9)
                l = DATA_W'($urandom_range(16, 1024));
            else
                l = rand48();
            send_item(OP_ADD, a, l, $urandom_range(9) != 0, pick_gap(pct));
        end
        else if (k < 55)
        begin
            if (j == 0)
                l = '0;
            else if (j == 1)
                l = rand48();
            else if (j < 4)
                l = DATA_W'($urandom_range(1, 64));
            else
                l = DATA_W'($urandom_range(1, 4096));
            send_item(OP_ALLOC, rand48(), l, 1'($urandom_range(1)), pick_gap(pct));
        end
        else if (k < 90)
        begin
            if (live_q.size() > 0 && $urandom_range(9) != 0)
            begin
                idx = $urandom_range(live_q.size() - 1);
                a = live_q[idx];
                live_q.delete(idx);
            end
            else
                a = (j < 5) ? rand48() : DATA_W'($urandom_range(0, 32'hFFFF));
            send_item(OP_REL, a, rand48(), 1'($urandom_range(1)), pick_gap(pct));
        end
        else
            send_item(OP_QUERY, rand48(), rand48(), 1'($urandom_range(1)), pick_gap(pct));
    endtask

    initial
    begin
        logic [DATA_W-1:0] min_set [4];
        int                pct [4];
        min_set = '{48'hFFFF_FFFF_FFFF, 48'd64, DEF_MIN_REGION, 48'd0};
        pct     = '{0, 82, 0, 12};
        issued = 0;
        returned = 0;
        cycles = 0;
        per_op = '{0, 0, 0, 0};
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_QUERY;
        address = '0;
        length = '0;
        usable = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_ADD, 48'h1000, 48'h100, 1'b1, 0);
        drain();
        write_min(48'd0);
        send_item(OP_QUERY, '0, '0, 1'b0, 0);
        send_item(OP_ALLOC, '0, '0, 1'b1, 0);
        send_item(OP_ADD, 48'h2000, 48'h100, 1'b0, 0);
        send_item(OP_ADD, 48'h3000, 48'd15, 1'b1, 0);
        send_item(OP_ADD, 48'h1000, 48'h100, 1'b1, 0);
        send_item(OP_ADD, 48'h0, 48'd16, 1'b1, 0);
        send_item(OP_ADD, 48'hFFFF_FFFF_FF00, 48'hFF, 1'b1, 0);
        send_item(OP_ALLOC, '0, 48'd1, 1'b0, 0);
        send_item(OP_ALLOC, '0, 48'hFFFF_FFFF_FFFF, 1'b0, 0);
        send_item(OP_ALLOC, '0, 48'd200, 1'b0, 0);
        send_item(OP_REL, 48'h1010, '0, 1'b0, 0);
        send_item(OP_REL, 48'h1010, '0, 1'b0, 0);
        send_item(OP_REL, 48'h0, '0, 1'b0, 0);
        send_item(OP_ADD, 48'h0, 48'hFFFF_FFFF_FFFF, 1'b1, 0);
        send_item(OP_QUERY, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 0);
        send_item(OP_ALLOC, '0, 48'hFFFF_FFFF_FFF0, 1'b0, 0);
        send_item(OP_ALLOC, '0, 48'hFFFF_FFFF_FF00, 1'b0, 0);
        send_item(OP_QUERY, '0, '0, 1'b0, 0);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            write_min(min_set[p]);
            for (int n = 0; n < 320; n++)
            begin
                random_item(pct[p]);
                if (p == 1 && n == 160)
                    drain();
            end
            drain();
        end

        $display("Ran %0d requests: %0d add, %0d allocate, %0d release, %0d query,",
                 issued, per_op[OP_ADD], per_op[OP_ALLOC], per_op[OP_REL], per_op[OP_QUERY]);
        $display("across four minimum-region settings and several idle patterns.");
        if (mismatches == 0 && waiting == 0 && returned == issued)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ffa_pkg.sv
rtl/ffa_alu.sv
rtl/first_fit_heap_allocator.sv
dv/heap_checker.sv
dv/tb.sv
